### hw/rtl/stree_pkg.sv
// Shared constants and controller/datapath command and status types for the segment tree.
package stree_pkg;

	// Tree geometry
	localparam int LEAVES = 1024;
	localparam int NODES  = 2 * LEAVES;
	localparam int NODE_W = $clog2(NODES);
	localparam int BND_W  = NODE_W + 1;

	// Field widths
	localparam int POS_W   = 10;
	localparam int RANGE_W = 11;
	localparam int DATA_W  = 32;

	// Operation codes carried in func
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic leaf_rd;
		logic leaf_wr;
		logic up_step;
		logic q_lo;
		logic q_hi;
		logic res_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic in_query;
		logic pos_ok;
		logic lo_lt_hi;
		logic up_last;
	} status_t;

endpackage

### hw/rtl/stree_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface stree_req_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic [stree_pkg::POS_W-1:0]        position;
	logic signed [stree_pkg::DATA_W-1:0] delta;
	logic [stree_pkg::RANGE_W-1:0]      range_low;
	logic [stree_pkg::RANGE_W-1:0]      range_high;

	modport source(output valid, output func, output position, output delta,
		output range_low, output range_high, input ready);
	modport sink(input valid, input func, input position, input delta,
		input range_low, input range_high, output ready);
endinterface

interface stree_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [stree_pkg::DATA_W-1:0] sum;

	modport source(output valid, output sum, input ready);
	modport sink(input valid, input sum, output ready);
endinterface

### hw/rtl/stree_dp.sv
// Datapath: node memory, walk registers, accumulator and result register.
module stree_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stree_pkg::cmd_t                     cmd,
	output stree_pkg::status_t                  st,
	input  logic                                in_func,
	input  logic [stree_pkg::POS_W-1:0]         in_position,
	input  logic signed [stree_pkg::DATA_W-1:0] in_delta,
	input  logic [stree_pkg::RANGE_W-1:0]       in_range_low,
	input  logic [stree_pkg::RANGE_W-1:0]       in_range_high,
	output logic signed [stree_pkg::DATA_W-1:0] sum
);

	logic [stree_pkg::DATA_W-1:0] mem [0:stree_pkg::NODES-1];
	logic [stree_pkg::DATA_W-1:0] rd_data_q;
	logic [stree_pkg::NODE_W-1:0] node_q;
	logic [stree_pkg::NODE_W-1:0] clr_cnt_q;
	logic [stree_pkg::BND_W-1:0]  lo_q;
	logic [stree_pkg::BND_W-1:0]  hi_q;
	logic [stree_pkg::DATA_W-1:0] delta_q;
	logic [stree_pkg::DATA_W-1:0] cur_q;
	logic [stree_pkg::DATA_W-1:0] acc_q;
	logic [stree_pkg::DATA_W-1:0] sum_q;
	logic                         pend_q;
	logic                         pos_ok_q;

	logic [stree_pkg::NODE_W-1:0] node_par;
	logic [stree_pkg::BND_W-1:0]  hi_m1;
	logic [stree_pkg::DATA_W-1:0] leaf_sum;
	logic [stree_pkg::DATA_W-1:0] up_sum;
	logic                         we;
	logic [stree_pkg::NODE_W-1:0] waddr;
	logic [stree_pkg::NODE_W-1:0] raddr;
	logic [stree_pkg::DATA_W-1:0] wdata;
	logic [stree_pkg::BND_W-1:0]  lo_clamp;
	logic [stree_pkg::BND_W-1:0]  hi_clamp;

	assign node_par = node_q >> 1;
	assign hi_m1    = hi_q - stree_pkg::BND_W'(1);
	assign leaf_sum = rd_data_q + delta_q;
	assign up_sum   = cur_q + rd_data_q;

	// Clamp query bounds to the leaf count
	assign lo_clamp = (32'(in_range_low) > 32'(stree_pkg::LEAVES)) ?
		stree_pkg::BND_W'(stree_pkg::LEAVES) : stree_pkg::BND_W'(in_range_low);
	assign hi_clamp = (32'(in_range_high) > 32'(stree_pkg::LEAVES)) ?
		stree_pkg::BND_W'(stree_pkg::LEAVES) : stree_pkg::BND_W'(in_range_high);

	// Memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = '0;
		raddr = node_q;
		if (cmd.clr_step) begin
			we = 1'b1;
		end
		if (cmd.leaf_rd) begin
			raddr = node_q;
		end
		if (cmd.leaf_wr) begin
			we    = 1'b1;
			waddr = node_q;
			wdata = leaf_sum;
			raddr = node_q ^ stree_pkg::NODE_W'(1);
		end
		if (cmd.up_step) begin
			we    = 1'b1;
			waddr = node_par;
			wdata = up_sum;
			raddr = node_par ^ stree_pkg::NODE_W'(1);
		end
		if (cmd.q_lo) begin
			raddr = lo_q[stree_pkg::NODE_W-1:0];
		end
		if (cmd.q_hi) begin
			raddr = hi_m1[stree_pkg::NODE_W-1:0];
		end
	end

	// Node memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// Control registers: clear sweep and pending accumulate flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + stree_pkg::NODE_W'(1);
			end
			if (cmd.q_lo) begin
				pend_q <= lo_q[0];
			end else if (cmd.q_hi) begin
				pend_q <= hi_q[0];
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	// Walk registers and accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q   <= stree_pkg::NODE_W'(stree_pkg::LEAVES) + stree_pkg::NODE_W'(in_position);
			pos_ok_q <= 32'(in_position) < 32'(stree_pkg::LEAVES);
			delta_q  <= in_delta;
			lo_q     <= stree_pkg::BND_W'(stree_pkg::LEAVES) + lo_clamp;
			hi_q     <= stree_pkg::BND_W'(stree_pkg::LEAVES) + hi_clamp;
			acc_q    <= '0;
		end else if (pend_q) begin
			acc_q <= acc_q + rd_data_q;
		end
		if (cmd.leaf_wr) begin
			cur_q <= leaf_sum;
		end
		if (cmd.up_step) begin
			cur_q  <= up_sum;
			node_q <= node_par;
		end
		if (cmd.q_lo && lo_q[0]) begin
			lo_q <= lo_q + stree_pkg::BND_W'(1);
		end
		if (cmd.q_hi) begin
			lo_q <= lo_q >> 1;
			hi_q <= (hi_q[0] ? hi_m1 : hi_q) >> 1;
		end
		if (cmd.res_load) begin
			sum_q <= acc_q;
		end
	end

	assign sum = $signed(sum_q);

	// Status back to the controller
	assign st.clr_last = clr_cnt_q == stree_pkg::NODE_W'(stree_pkg::NODES - 1);
	assign st.in_query = in_func == stree_pkg::FUNC_QUERY;
	assign st.pos_ok   = pos_ok_q;
	assign st.lo_lt_hi = lo_q < hi_q;
	assign st.up_last  = node_par == stree_pkg::NODE_W'(1);

	// The update walk never steps above the root
	a_up_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_step |-> node_q > stree_pkg::NODE_W'(1))
		else $error("update walk stepped past the root");

endmodule

### hw/rtl/stree_ctrl.sv
// Controller: sequences clearing, point updates and range queries.
module stree_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output stree_pkg::cmd_t    cmd,
	input  stree_pkg::status_t st
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LEAF  = 3'd2;
	localparam logic [2:0] S_LEAFW = 3'd3;
	localparam logic [2:0] S_UP    = 3'd4;
	localparam logic [2:0] S_QLO   = 3'd5;
	localparam logic [2:0] S_QHI   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign req_ready = state_q == S_IDLE;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = st.in_query ? S_QLO : S_LEAF;
				end
			end
			S_LEAF: begin
				if (st.pos_ok) begin
					cmd.leaf_rd = 1'b1;
					state_d     = S_LEAFW;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LEAFW: begin
				cmd.leaf_wr = 1'b1;
				state_d     = S_UP;
			end
			S_UP: begin
				cmd.up_step = 1'b1;
				if (st.up_last) begin
					state_d = S_IDLE;
				end
			end
			S_QLO: begin
				if (st.lo_lt_hi) begin
					cmd.q_lo = 1'b1;
					state_d  = S_QHI;
				end else begin
					state_d = S_DONE;
				end
			end
			S_QHI: begin
				cmd.q_hi = 1'b1;
				state_d  = S_QLO;
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req_ready)
		else $error("request taken during memory clear");

	a_up_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && st.up_last) |=> (state_q == S_IDLE))
		else $error("update walk did not end at the root");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> rsp_valid)
		else $error("loaded result not presented");

endmodule

### hw/rtl/segment_tree_point_add_range_sum_top.sv
// Top level of the point-add, range-sum segment tree.
//
// Channel  Dir  Fields                                        Transaction
// req      in   func, position, delta, range_low, range_high  one add or query
// rsp      out  sum                                           one query result
//
// Add: a leaf read, a leaf write, then one update step per tree level above the leaf
// (10 levels at 1024 leaves). Query: a low step and a high step per level walked (up to
// 11 levels), through one node memory read port. Adds give no response.
// After reset a clearing sweep writes zero to all 2048 nodes, one per cycle; req.ready
// stays low until the sweep ends.
// A held result sits in the output register; a new request is taken meanwhile, and a
// query finishing behind an untaken result waits for it.
module segment_tree_point_add_range_sum_top (
	input  logic        clk,
	input  logic        arst_n,
	stree_req_if.sink   req,
	stree_rsp_if.source rsp
);

	stree_pkg::cmd_t    cmd;
	stree_pkg::status_t st;

	stree_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	stree_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_func       (req.func),
		.in_position   (req.position),
		.in_delta      (req.delta),
		.in_range_low  (req.range_low),
		.in_range_high (req.range_high),
		.sum           (rsp.sum)
	);

endmodule
